[sv/lfsa_pkg.sv]
// Shared types and constants for the lowest free slot allocator.
// No dependencies; every other file of the block imports this package.
package lfsa_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int ID_SPACE_DEF = 1024;

  localparam int ID_W       = 10;
  localparam int CFG_W      = 7;
  localparam int COUNT_W    = 20;
  localparam int SLOT_OUT_W = 6;

  // The free-slot search looks at one group of this many slots per cycle.
  localparam int GROUP_W  = 8;
  localparam int GROUP_AW = $clog2(GROUP_W);

  localparam logic [CFG_W-1:0]   CFG_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DEPART = 1'b1;

  typedef enum logic [1:0] {
    ST_ASSIGNED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_RELEASED = 2'd2,
    ST_NO_SLOT  = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic start;
    logic decide;
    logic step;
    logic commit;
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic need_search;
    logic search_done;
  } dp_stat_t;

endpackage

[sv/lfsa_ctrl.sv]
// Controller of the lowest free slot allocator: sequences the clearing pass,
// lookup, search and commit of each request. Depends on lfsa_pkg.
module lfsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lfsa_pkg::dp_ctrl_t ctrl,
  input  lfsa_pkg::dp_stat_t stat
);
  import lfsa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_SEARCH,
    S_COMMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctrl        = '0;
    ctrl.clear  = (state == S_CLEAR);
    ctrl.start  = (state == S_IDLE) && in_valid;
    ctrl.decide = (state == S_LOOKUP);
    ctrl.step   = (state == S_SEARCH);
    ctrl.commit = (state == S_COMMIT) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_next = stat.need_search ? S_SEARCH : S_COMMIT;
      end
      S_SEARCH: begin
        if (stat.search_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (ctrl.commit) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/lfsa_dp.sv]
// Datapath of the lowest free slot allocator: id map and served count memories,
// busy map, group-wise free-slot search and the result register. Uses lfsa_pkg.
module lfsa_dp #(
  parameter int SLOTS    = lfsa_pkg::SLOTS_DEF,
  parameter int ID_SPACE = lfsa_pkg::ID_SPACE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lfsa_pkg::dp_ctrl_t              ctrl,
  output lfsa_pkg::dp_stat_t              stat,
  input  logic                            in_cmd,
  input  logic [lfsa_pkg::ID_W-1:0]       in_id,
  input  logic                            cfg_we,
  input  logic [lfsa_pkg::CFG_W-1:0]      cfg_data,
  output lfsa_pkg::status_t               out_status,
  output logic [lfsa_pkg::SLOT_OUT_W-1:0] out_slot,
  output logic [lfsa_pkg::COUNT_W-1:0]    out_count
);
  import lfsa_pkg::*;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int ENTRY_W = $clog2(SLOTS + 1);
  localparam int LIM_W   = $clog2(SLOTS + 1);
  localparam int MAP_AW  = $clog2(ID_SPACE);
  localparam int NGROUPS = (SLOTS + GROUP_W - 1) / GROUP_W;
  localparam int GRP_IW  = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int PAD_W   = NGROUPS * GROUP_W;
  localparam int CLR_LEN = (ID_SPACE > SLOTS) ? ID_SPACE : SLOTS;
  localparam int CLR_W   = $clog2(CLR_LEN);

  // Each id map entry holds the slot plus one, zero meaning no slot.
  logic [ENTRY_W-1:0] id_map [ID_SPACE];
  logic [COUNT_W-1:0] counts [SLOTS];

  logic [SLOTS-1:0] busy;
  logic [PAD_W-1:0] busy_pad;
  logic [CFG_W-1:0] slots_in_use;
  logic [CLR_W-1:0] clr_idx;

  logic               cmd_q;
  logic [MAP_AW-1:0]  id_q;
  logic               id_ok_q;
  logic [ENTRY_W-1:0] map_rd;
  logic [COUNT_W-1:0] count_rd;
  logic [GRP_IW-1:0]  grp;

  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic              res_alloc;
  logic              res_release;
  logic              res_count;

  logic [LIM_W-1:0]    limit;
  logic                hit;
  logic [SLOT_W-1:0]   hit_slot;
  logic [GROUP_W-1:0]  grp_busy;
  logic [GROUP_W-1:0]  elig;
  logic                found;
  logic [GROUP_AW-1:0] pick;
  logic [SLOT_W-1:0]   found_slot;
  logic                last;
  logic [COUNT_W-1:0]  count_inc;

  logic               count_re;
  logic [SLOT_W-1:0]  count_ra;
  logic               map_we;
  logic [MAP_AW-1:0]  map_wa;
  logic [ENTRY_W-1:0] map_wd;
  logic               cnt_we;
  logic [SLOT_W-1:0]  cnt_wa;
  logic [COUNT_W-1:0] cnt_wd;

  // Slots past the end of the last group read as busy.
  for (genvar gi = 0; gi < PAD_W; gi++) begin : g_pad
    if (gi < SLOTS) begin : g_real
      assign busy_pad[gi] = busy[gi];
    end else begin : g_fill
      assign busy_pad[gi] = 1'b1;
    end
  end

  always_comb begin
    if (32'(slots_in_use) < SLOTS) begin
      limit = LIM_W'(slots_in_use);
    end else begin
      limit = LIM_W'(SLOTS);
    end
  end

  assign hit      = (map_rd != '0);
  assign hit_slot = SLOT_W'(map_rd - ENTRY_W'(1));
  assign grp_busy = busy_pad[32'(grp) * GROUP_W +: GROUP_W];

  always_comb begin
    logic [GRP_IW+GROUP_AW-1:0] cand;
    cand = '0;
    for (int j = 0; j < GROUP_W; j++) begin
      cand    = {grp, GROUP_AW'(j)};
      elig[j] = !grp_busy[j] && (32'(cand) < 32'(limit));
    end
    pick = '0;
    for (int j = GROUP_W - 1; j >= 0; j--) begin
      if (elig[j]) pick = GROUP_AW'(j);
    end
  end

  assign found      = |elig;
  assign found_slot = SLOT_W'({grp, pick});
  assign last       = (32'(grp) == NGROUPS - 1) ||
                      ((32'(grp) + 32'd1) * GROUP_W >= 32'(limit));
  assign count_inc  = (count_rd == COUNT_MAX) ? count_rd : count_rd + COUNT_W'(1);

  always_comb begin
    stat             = '0;
    stat.clear_done  = (32'(clr_idx) == CLR_LEN - 1);
    stat.need_search = id_ok_q && (cmd_q == CMD_ARRIVE) && !hit;
    stat.search_done = found || last;
  end

  assign count_re = (ctrl.decide && id_ok_q && hit) || (ctrl.step && found);
  assign count_ra = ctrl.step ? found_slot : hit_slot;

  assign map_we = (ctrl.clear && (32'(clr_idx) < ID_SPACE)) ||
                  (ctrl.commit && (res_alloc || res_release));
  assign map_wa = ctrl.clear ? MAP_AW'(clr_idx) : id_q;
  assign map_wd = (ctrl.clear || !res_alloc) ? '0 : ENTRY_W'(res_slot) + ENTRY_W'(1);

  assign cnt_we = (ctrl.clear && (32'(clr_idx) < SLOTS)) || (ctrl.commit && res_alloc);
  assign cnt_wa = ctrl.clear ? SLOT_W'(clr_idx) : res_slot;
  assign cnt_wd = ctrl.clear ? '0 : count_inc;

  always_ff @(posedge clk) begin
    if (map_we) id_map[map_wa] <= map_wd;
    if (ctrl.start) map_rd <= id_map[MAP_AW'(in_id)];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) counts[cnt_wa] <= cnt_wd;
    if (count_re) count_rd <= counts[count_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= '0;
      slots_in_use <= CFG_RESET;
      clr_idx      <= '0;
    end else begin
      if (cfg_we) slots_in_use <= cfg_data;
      if (ctrl.clear && !stat.clear_done) clr_idx <= clr_idx + CLR_W'(1);
      if (ctrl.commit && res_alloc) busy[res_slot] <= 1'b1;
      if (ctrl.commit && res_release) busy[res_slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cmd_q   <= in_cmd;
      id_q    <= MAP_AW'(in_id);
      id_ok_q <= (32'(in_id) < ID_SPACE);
      grp     <= '0;
    end
    if (ctrl.decide) begin
      res_alloc <= 1'b0;
      if (id_ok_q && hit) begin
        res_status  <= (cmd_q == CMD_ARRIVE) ? ST_ASSIGNED : ST_RELEASED;
        res_slot    <= hit_slot;
        res_count   <= 1'b1;
        res_release <= (cmd_q == CMD_DEPART);
      end else begin
        res_status  <= (cmd_q == CMD_DEPART) ? ST_NO_SLOT : ST_REJECTED;
        res_slot    <= '0;
        res_count   <= 1'b0;
        res_release <= 1'b0;
      end
    end
    if (ctrl.step) begin
      if (found) begin
        res_status <= ST_ASSIGNED;
        res_slot   <= found_slot;
        res_alloc  <= 1'b1;
        res_count  <= 1'b1;
      end else if (!last) begin
        grp <= grp + GRP_IW'(1);
      end
    end
    if (ctrl.commit) begin
      out_status <= res_status;
      out_slot   <= res_count ? SLOT_OUT_W'(res_slot) : '0;
      if (res_alloc) begin
        out_count <= count_inc;
      end else if (res_count) begin
        out_count <= count_rd;
      end else begin
        out_count <= '0;
      end
    end
  end

endmodule

[sv/lowest_free_slot_allocator.sv]
// Top level of the lowest free slot allocator: joins the controller and the
// datapath. Depends on lfsa_pkg, lfsa_ctrl and lfsa_dp.
//
// Use: each request on the input channel carries cmd (arrive or depart) and
// request_id. An arrive takes the lowest free slot below slots_in_use (capped
// at SLOTS); a depart frees the slot the id holds. Exactly one result per
// request comes out on the output channel with status, slot and served_count.
// The configuration channel writes slots_in_use and is always ready.
// After reset a clearing pass over max(ID_SPACE, SLOTS) entries (1024 by default)
// empties the id map and zeroes the served counts; in_ready stays low during
// it, while configuration writes are taken as usual.
// An accepted request goes from the lookup state to the commit state, which
// loads the result and out_valid, when the id map decides it; an arrive that
// must search passes through the search state in between, scanning one 8-slot
// group per cycle, from 1 up to max(1, ceil(limit / 8)) groups. The next
// request can be accepted in the cycle after the commit. The read-modify-write
// of the single-port id map and the group-serial busy search set this sequence;
// one request is worked on at a time.
// The result sits in an output register: if the receiver stalls, the next
// request is still accepted and worked on up to its commit, where it waits.
module lowest_free_slot_allocator #(
  parameter int SLOTS    = lfsa_pkg::SLOTS_DEF,
  parameter int ID_SPACE = lfsa_pkg::ID_SPACE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [lfsa_pkg::ID_W-1:0]       request_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lfsa_pkg::status_t               status,
  output logic [lfsa_pkg::SLOT_OUT_W-1:0] slot,
  output logic [lfsa_pkg::COUNT_W-1:0]    served_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lfsa_pkg::CFG_W-1:0]      slots_in_use
);
  import lfsa_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  lfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  lfsa_dp #(
    .SLOTS    (SLOTS),
    .ID_SPACE (ID_SPACE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_cmd     (cmd),
    .in_id      (request_id),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (slots_in_use),
    .out_status (status),
    .out_slot   (slot),
    .out_count  (served_count)
  );

endmodule

[sv/lfsa_checker.sv]
// Port-level checks for the lowest free slot allocator, bound to the top level.
// Depends on lfsa_pkg and lowest_free_slot_allocator.
module lfsa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input lfsa_pkg::status_t               status,
  input logic [lfsa_pkg::SLOT_OUT_W-1:0] slot,
  input logic [lfsa_pkg::COUNT_W-1:0]    served_count
);
  import lfsa_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot) &&
      $stable(served_count))
    else $error("result changed while stalled");

  // Rejected requests and departs without a slot report slot and count as zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_REJECTED || status == ST_NO_SLOT) |->
      slot == '0 && served_count == '0)
    else $error("non-zero payload on a request without a slot");

  // A slot that is held has served at least the request holding it.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ASSIGNED || status == ST_RELEASED) |->
      served_count != '0)
    else $error("held slot reports a zero served count");

  // One request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in progress");

  // Reset leaves no result pending and starts the clearing pass.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

endmodule

bind lowest_free_slot_allocator lfsa_checker u_lfsa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .slot         (slot),
  .served_count (served_count)
);

[tb/tb_top.sv]
// Self-checking testbench for lowest_free_slot_allocator: directed table, then random phases.
// Each phase sets its own slot count. An in-bench predictor supplies the expected results.
// Depends on lfsa_pkg and the allocator RTL only.
module tb_top;
  import lfsa_pkg::*;

  typedef struct packed {
    status_t                 st;
    logic [SLOT_OUT_W-1:0]   slot;
    logic [COUNT_W-1:0]      count;
  } slot_grant_t;

  typedef enum bit {ROW_EVENT, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic             c;
    logic [ID_W-1:0]  rid;
    logic [CFG_W-1:0] cfg_val;
    bit               typed;
    slot_grant_t      want;
  } plan_row_t;

  typedef struct {
    bit               pick_random;
    logic [CFG_W-1:0] cfg_val;
    int               items;
    int               arrive_pct;
    int               pool;
    bit               calm;
    bit               squeeze;
  } phase_t;

  localparam int PLAN_N      = 22;
  localparam int PHASE_N     = 9;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 16;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  cmd;
  logic [ID_W-1:0]       request_id;
  logic                  out_valid;
  logic                  out_ready;
  status_t               status;
  logic [SLOT_OUT_W-1:0] slot;
  logic [COUNT_W-1:0]    served_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      slots_in_use;

  lowest_free_slot_allocator u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .request_id   (request_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .slot         (slot),
    .served_count (served_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .slots_in_use (slots_in_use)
  );

  // Predictor state: a mirror of the allocator's occupancy, id map and counts.
  logic               busy_slots [SLOTS_DEF];
  logic [6:0]         id_holds [ID_SPACE_DEF];
  logic [COUNT_W-1:0] served [SLOTS_DEF];
  int                 slot_limit;

  slot_grant_t pending_grants[$];
  int          mismatches;
  int          requests_sent;
  int          results_checked;
  int          cfg_writes;
  int          status_seen [4];
  bit          calm;
  bit          squeeze_req;

  plan_row_t directed_plan [PLAN_N];
  phase_t    phases [PHASE_N];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Works out the answer to one request and updates the mirrored state.
  function automatic slot_grant_t model_slot_event(input logic c, input logic [ID_W-1:0] rid);
    slot_grant_t g;
    int          eff;
    int          s;
    int          held;
    g    = '{ST_NO_SLOT, '0, '0};
    eff  = (slot_limit > SLOTS_DEF) ? SLOTS_DEF : slot_limit;
    held = id_holds[rid];
    if (c == CMD_ARRIVE) begin
      if (held != 0) begin
        // An id that already holds a slot keeps it; nothing is counted.
        g = '{ST_ASSIGNED, SLOT_OUT_W'(held - 1), served[held - 1]};
      end else begin
        s = 0;
        while (s < eff && busy_slots[s]) s++;
        if (s >= eff) begin
          g = '{ST_REJECTED, '0, '0};
        end else begin
          busy_slots[s] = 1'b1;
          id_holds[rid] = 7'(s + 1);
          if (served[s] != COUNT_MAX) served[s]++;
          g = '{ST_ASSIGNED, SLOT_OUT_W'(s), served[s]};
        end
      end
    end else if (held != 0) begin
      // A depart frees its slot even when the slot count has since been lowered.
      id_holds[rid]        = '0;
      busy_slots[held - 1] = 1'b0;
      g = '{ST_RELEASED, SLOT_OUT_W'(held - 1), served[held - 1]};
    end
    return g;
  endfunction

  task automatic send_event(input logic c, input logic [ID_W-1:0] rid, input int gap,
                            input bit typed, input slot_grant_t want);
    slot_grant_t g;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    cmd        = c;
    request_id = rid;
    do @(posedge clk); while (!in_ready);
    g = model_slot_event(c, rid);
    pending_grants.push_back(typed ? want : g);
    requests_sent++;
    @(negedge clk);
  endtask

  // Register writes only happen once every outstanding request has answered.
  task automatic write_slot_count(input logic [CFG_W-1:0] v);
    in_valid = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid    = 1'b1;
    slots_in_use = v;
    do @(posedge clk); while (!cfg_ready);
    slot_limit = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin
    slot_grant_t w;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      status_seen[status]++;
      if (pending_grants.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %s slot %0d count %0d",
                                status.name(), slot, served_count));
      end else begin
        w = pending_grants.pop_front();
        if (status !== w.st)
          flag_mismatch($sformatf("status got %s want %s", status.name(), w.st.name()));
        if (slot !== w.slot)
          flag_mismatch($sformatf("slot got %0d want %0d", slot, w.slot));
        if (served_count !== w.count)
          flag_mismatch($sformatf("served_count got %0d want %0d", served_count, w.count));
      end
    end
  end

  // Receiver: a fresh stall per result, and one long hold-off when asked for.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (squeeze_req) begin
        stall       = HOLD_CYCLES;
        squeeze_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] v;
    logic             c;
    logic [ID_W-1:0]  rid;
    int               wait_cycles;
    clk          = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = CMD_ARRIVE;
    request_id   = '0;
    cfg_valid    = 1'b0;
    slots_in_use = CFG_RESET;
    calm         = 1'b0;
    squeeze_req  = 1'b0;
    mismatches   = 0;
    requests_sent   = 0;
    results_checked = 0;
    cfg_writes      = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (busy_slots[i]) busy_slots[i] = 1'b0;
    foreach (served[i]) served[i] = '0;
    foreach (id_holds[i]) id_holds[i] = '0;
    slot_limit = CFG_RESET;

    directed_plan = '{
      '{ROW_EVENT,  CMD_DEPART, 10'd0,     7'd0,   1'b1, '{ST_NO_SLOT,  6'd0, 20'd0}},
      '{ROW_EVENT,  CMD_ARRIVE, 10'd0,     7'd0,   1'b1, '{ST_ASSIGNED, 6'd0, 20'd1}},
      '{ROW_EVENT,  CMD_ARRIVE, 10'd1023,  7'd0,   1'b1, '{ST_ASSIGNED, 6'd1, 20'd1}},
      '{ROW_EVENT,  CMD_ARRIVE, 10'd0,     7'd0,   1'b1, '{ST_ASSIGNED, 6'd0, 20'd1}},
      '{ROW_EVENT,  CMD_DEPART, 10'd0,     7'd0,   1'b1, '{ST_RELEASED, 6'd0, 20'd1}},
      '{ROW_EVENT,  CMD_ARRIVE, 10'h2AA,   7'd0,   1'b1, '{ST_ASSIGNED, 6'd0, 20'd2}},
      '{ROW_EVENT,  CMD_ARRIVE, 10'h155,   7'd0,   1'b1, '{ST_ASSIGNED, 6'd2, 20'd1}},
      '{ROW_CONFIG, CMD_ARRIVE, 10'd0,     7'd0,   1'b0, '{ST_ASSIGNED, 6'd0, 20'd0}},
      '{ROW_EVENT,  CMD_ARRIVE, 10'd5,     7'd0,   1'b1, '{ST_REJECTED, 6'd0, 20'd0}},
      '{ROW_EVENT,  CMD_DEPART, 10'd1023,  7'd0,   1'b1, '{ST_RELEASED, 6'd1, 20'd1}},
      '{ROW_EVENT,  CMD_ARRIVE, 10'd1023,  7'd0,   1'b1, '{ST_REJECTED, 6'd0, 20'd0}},
      '{ROW_CONFIG, CMD_ARRIVE, 10'd0,     7'd1,   1'b0, '{ST_ASSIGNED, 6'd0, 20'd0}},
      '{ROW_EVENT,  CMD_ARRIVE, 10'd5,     7'd0,   1'b1, '{ST_REJECTED, 6'd0, 20'd0}},
      '{ROW_EVENT,  CMD_DEPART, 10'h2AA,   7'd0,   1'b1, '{ST_RELEASED, 6'd0, 20'd2}},
      '{ROW_EVENT,  CMD_ARRIVE, 10'd5,     7'd0,   1'b1, '{ST_ASSIGNED, 6'd0, 20'd3}},
      '{ROW_EVENT,  CMD_ARRIVE, 10'd6,     7'd0,   1'b1, '{ST_REJECTED, 6'd0, 20'd0}},
      '{ROW_CONFIG, CMD_ARRIVE, 10'd0,     7'd127, 1'b0, '{ST_ASSIGNED, 6'd0, 20'd0}},
      '{ROW_EVENT,  CMD_ARRIVE, 10'd6,     7'd0,   1'b0, '{ST_ASSIGNED, 6'd0, 20'd0}},
      '{ROW_EVENT,  CMD_ARRIVE, 10'd6,     7'd0,   1'b0, '{ST_ASSIGNED, 6'd0, 20'd0}},
      '{ROW_EVENT,  CMD_DEPART, 10'd6,     7'd0,   1'b0, '{ST_ASSIGNED, 6'd0, 20'd0}},
      '{ROW_EVENT,  CMD_DEPART, 10'd5,     7'd0,   1'b0, '{ST_ASSIGNED, 6'd0, 20'd0}},
      '{ROW_EVENT,  CMD_DEPART, 10'h155,   7'd0,   1'b0, '{ST_ASSIGNED, 6'd0, 20'd0}}
    };

    // The count of 127 runs past the slot total; a count of 0 rejects every arrive from an id that holds no slot.
    phases = '{
      '{1'b0, 7'd127, 300, 80, 100, 1'b0, 1'b0},
      '{1'b0, 7'd0,    40, 50, 100, 1'b0, 1'b0},
      '{1'b0, 7'd5,   200, 60,  40, 1'b1, 1'b0},
      '{1'b0, 7'd64,  300, 70, 128, 1'b0, 1'b1},
      '{1'b0, 7'd1,   100, 50,   8, 1'b0, 1'b0},
      '{1'b0, 7'd65,  200, 75,  90, 1'b0, 1'b0},
      '{1'b1, 7'd0,   170, 65,  80, 1'b0, 1'b0},
      '{1'b1, 7'd0,   170, 65,  80, 1'b1, 1'b0},
      '{1'b1, 7'd0,   170, 65,  80, 1'b0, 1'b0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CONFIG)
        write_slot_count(directed_plan[i].cfg_val);
      else
        send_event(directed_plan[i].c, directed_plan[i].rid, $urandom_range(0, 4),
                   directed_plan[i].typed, directed_plan[i].want);
    end

    // Mostly arrives and departs over a small pool of ids, so the slots fill
    // and drain; about one request in ten carries an id from the whole range.
    foreach (phases[p]) begin
      v = phases[p].pick_random ? CFG_W'($urandom_range(0, 127)) : phases[p].cfg_val;
      write_slot_count(v);
      calm        = phases[p].calm;
      squeeze_req = phases[p].squeeze;
      for (int n = 0; n < phases[p].items; n++) begin
        c   = ($urandom_range(0, 99) < phases[p].arrive_pct) ? CMD_ARRIVE : CMD_DEPART;
        rid = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, ID_SPACE_DEF - 1))
                                          : ID_W'($urandom_range(0, phases[p].pool - 1));
        send_event(c, rid, calm ? 0 : $urandom_range(0, 4), 1'b0, '{ST_ASSIGNED, '0, '0});
      end
    end
    calm     = 1'b0;
    in_valid = 1'b0;

    wait_cycles = 0;
    while (pending_grants.size() != 0 && wait_cycles < 5000) begin
      @(negedge clk);
      wait_cycles++;
    end
    if (pending_grants.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_grants.size()));
    repeat (SETTLE) @(negedge clk);

    $display("Run covered %0d requests, %0d results checked, %0d slot count writes.",
             requests_sent, results_checked, cfg_writes);
    $display("Answers seen: %0d assigned, %0d rejected, %0d released, %0d without a slot.",
             status_seen[ST_ASSIGNED], status_seen[ST_REJECTED],
             status_seen[ST_RELEASED], status_seen[ST_NO_SLOT]);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
